FILE: rtl/kwlm_pkg.sv
package kwlm_pkg;

  // Field widths of the input and result transactions.
  localparam int VALUE_W = 32;
  localparam int LIST_W = 3;

  // Number of lists that the list number field can address.
  localparam int LIST_SLOTS = 2 ** LIST_W;

  // Default configuration.
  localparam int LISTS_DEF = 8;
  localparam int CAPACITY_DEF = 64;

  // Codes of the kind field.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_NEXT,
    ST_ADV,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_issue;
    logic cmp_en;
    logic next_rd;
    logic advance;
    logic emit_empty;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic store_empty;
    logic scan_end;
    logic out_last;
  } sts_t;

endpackage

FILE: rtl/kwlm_dp.sv
module kwlm_dp #(
  parameter int LISTS = kwlm_pkg::LISTS_DEF,
  parameter int CAPACITY = kwlm_pkg::CAPACITY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kwlm_pkg::cmd_t                       cmd_i,
  output kwlm_pkg::sts_t                       sts_o,
  input  logic        [kwlm_pkg::LIST_W-1:0]   list_number_i,
  input  logic signed [kwlm_pkg::VALUE_W-1:0]  value_i,
  output logic signed [kwlm_pkg::VALUE_W-1:0]  value_res_o,
  output logic        [kwlm_pkg::LIST_W-1:0]   list_number_res_o,
  output logic                                 last_o,
  output logic                                 empty_res_o,
  output logic                                 dropped_o
);

  // Lists beyond what the list number field can address never receive data.
  localparam int NumLists = (LISTS < kwlm_pkg::LIST_SLOTS) ? LISTS : kwlm_pkg::LIST_SLOTS;
  localparam int LstW = (NumLists > 1) ? $clog2(NumLists) : 1;
  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  // Element store: values and per-element link to the next element of its list.
  logic [kwlm_pkg::VALUE_W-1:0] val_mem [CAPACITY];
  logic [AddrW-1:0]             nxt_mem [CAPACITY];

  // Per-list head, tail and active flag.
  logic [AddrW-1:0]    head_q [NumLists];
  logic [AddrW-1:0]    tail_q [NumLists];
  logic [NumLists-1:0] active_q, active_d;

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  // Scan and compare state.
  logic [LstW-1:0]              scan_q;
  logic                         cmp_valid_q, cmp_valid_d;
  logic [LstW-1:0]              cmp_list_q;
  logic [AddrW-1:0]             cmp_ptr_q;
  logic [kwlm_pkg::VALUE_W-1:0] rd_val_q;
  logic                         have_q;
  logic [kwlm_pkg::VALUE_W-1:0] best_val_q;
  logic [LstW-1:0]              best_list_q;
  logic [AddrW-1:0]             best_ptr_q;
  logic [AddrW-1:0]             nxt_q;

  // Output register.
  logic [kwlm_pkg::VALUE_W-1:0] out_val_q;
  logic [kwlm_pkg::LIST_W-1:0]  out_list_q;
  logic                         out_last_q;
  logic                         out_empty_q;
  logic                         out_drop_q;

  logic             list_ok;
  logic             store_full;
  logic             do_store;
  logic [LstW-1:0]  lst_idx;
  logic [AddrW-1:0] wr_addr;
  logic [LstW-1:0]  tail_idx;
  logic [AddrW-1:0] tail_rd;
  logic [AddrW-1:0] head_rd;
  logic             best_is_tail;
  logic             take;

  // Load decode: lists outside the configured range are ignored.
  assign list_ok    = ({4'd0, list_number_i} < 7'(LISTS));
  assign lst_idx    = LstW'(list_number_i);
  assign store_full = (count_q == CntW'(CAPACITY));
  assign do_store   = cmd_i.load && list_ok && !store_full;
  assign wr_addr    = count_q[AddrW-1:0];

  // Tail lookup is shared between loading and merging, which never overlap.
  assign tail_idx     = cmd_i.load ? lst_idx : best_list_q;
  assign tail_rd      = tail_q[tail_idx];
  assign best_is_tail = (best_ptr_q == tail_rd);
  assign head_rd      = head_q[scan_q];

  // Later lists win ties, since they are scanned in ascending order.
  assign take = cmd_i.cmp_en && cmp_valid_q &&
                (!have_q || ($signed(rd_val_q) <= $signed(best_val_q)));

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      val_mem[wr_addr] <= value_i;
    end
    if (do_store && active_q[lst_idx]) begin
      nxt_mem[tail_rd] <= wr_addr;
    end
    if (cmd_i.scan_issue) begin
      rd_val_q <= val_mem[head_rd];
    end
    if (cmd_i.next_rd) begin
      nxt_q <= nxt_mem[best_ptr_q];
    end
  end

  // List heads and tails.
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      tail_q[lst_idx] <= wr_addr;
      if (!active_q[lst_idx]) begin
        head_q[lst_idx] <= wr_addr;
      end
    end
    if (cmd_i.advance && !best_is_tail) begin
      head_q[best_list_q] <= nxt_q;
    end
  end

  // Next values of the control registers.
  always_comb begin
    active_d = active_q;
    count_d = count_q;
    ovf_d = ovf_q;
    if (do_store) begin
      active_d[lst_idx] = 1'b1;
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.load && list_ok && store_full) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.advance) begin
      count_d = count_q - CntW'(1);
      if (best_is_tail) begin
        active_d[best_list_q] = 1'b0;
      end
    end
    if (cmd_i.clear) begin
      active_d = '0;
      count_d = '0;
      ovf_d = 1'b0;
    end
    cmp_valid_d = cmd_i.scan_issue ? active_q[scan_q] : 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      count_q <= '0;
      ovf_q <= 1'b0;
      scan_q <= '0;
      cmp_valid_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      active_q <= active_d;
      count_q <= count_d;
      ovf_q <= ovf_d;
      cmp_valid_q <= cmp_valid_d;
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        have_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_q <= scan_q + LstW'(1);
        end
        if (take) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // Candidate tag and running minimum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      cmp_list_q <= scan_q;
      cmp_ptr_q <= head_rd;
    end
    if (take) begin
      best_val_q <= rd_val_q;
      best_list_q <= cmp_list_q;
      best_ptr_q <= cmp_ptr_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      out_val_q <= best_val_q;
      out_list_q <= kwlm_pkg::LIST_W'(best_list_q);
      out_last_q <= (count_q == CntW'(1));
      out_empty_q <= 1'b0;
      out_drop_q <= ovf_q;
    end else if (cmd_i.emit_empty) begin
      out_val_q <= '0;
      out_list_q <= '0;
      out_last_q <= 1'b1;
      out_empty_q <= 1'b1;
      out_drop_q <= ovf_q;
    end
  end

  assign value_res_o       = out_val_q;
  assign list_number_res_o = out_list_q;
  assign last_o            = out_last_q;
  assign empty_res_o       = out_empty_q;
  assign dropped_o         = out_drop_q;

  assign sts_o.store_empty = (count_q == '0);
  assign sts_o.scan_end    = (scan_q == LstW'(NumLists - 1));
  assign sts_o.out_last    = out_last_q;

  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  // Every merge step finds a head to take.
  a_winner_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> have_q)
    else $error("merge step without a winner");

  // The final element is the tail of the only list still active.
  a_last_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> ((count_q == CntW'(1)) ==
      ((active_q == (NumLists'(1) << best_list_q)) && best_is_tail)))
    else $error("remaining count disagrees with list state");

  // A clear empties the store completely.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> ((count_q == '0) && (active_q == '0) && !ovf_q))
    else $error("store not empty after clear");

endmodule

FILE: rtl/kwlm_ctrl.sv
module kwlm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kwlm_pkg::cmd_t cmd_o,
  input  kwlm_pkg::sts_t sts_i
);

  kwlm_pkg::state_e state_q, state_d;

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && (state_q == kwlm_pkg::ST_IDLE);
  assign out_fire = out_ready_i && (state_q == kwlm_pkg::ST_EMIT);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kwlm_pkg::ST_IDLE: begin
        if (in_fire && (kind_i == kwlm_pkg::KIND_FINISH)) begin
          state_d = sts_i.store_empty ? kwlm_pkg::ST_EMIT : kwlm_pkg::ST_SCAN;
        end
      end
      kwlm_pkg::ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = kwlm_pkg::ST_LAST;
        end
      end
      kwlm_pkg::ST_LAST: state_d = kwlm_pkg::ST_NEXT;
      kwlm_pkg::ST_NEXT: state_d = kwlm_pkg::ST_ADV;
      kwlm_pkg::ST_ADV:  state_d = kwlm_pkg::ST_EMIT;
      kwlm_pkg::ST_EMIT: begin
        if (out_fire) begin
          state_d = sts_i.out_last ? kwlm_pkg::ST_IDLE : kwlm_pkg::ST_SCAN;
        end
      end
      default: state_d = kwlm_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      kwlm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire && (kind_i == kwlm_pkg::KIND_LOAD);
        cmd_o.scan_start = in_fire && (kind_i == kwlm_pkg::KIND_FINISH) && !sts_i.store_empty;
        cmd_o.emit_empty = in_fire && (kind_i == kwlm_pkg::KIND_FINISH) && sts_i.store_empty;
      end
      kwlm_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        cmd_o.cmp_en = 1'b1;
      end
      kwlm_pkg::ST_LAST: cmd_o.cmp_en = 1'b1;
      kwlm_pkg::ST_NEXT: cmd_o.next_rd = 1'b1;
      kwlm_pkg::ST_ADV:  cmd_o.advance = 1'b1;
      kwlm_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = out_fire && sts_i.out_last;
        cmd_o.scan_start = out_fire && !sts_i.out_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwlm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/k_way_list_merge_top.sv
// K-way merge of sorted lists. Load transactions (kind 0) append one signed value to the list
// given by list_number and are taken one per cycle while no finish is in progress; list numbers
// not below LISTS are ignored, and loads past CAPACITY are dropped and flagged in every result of
// the next finish. A finish transaction (kind 1) emits all stored values in ascending order, ties
// going to the higher list number, marks the final result with last, and then clears the store;
// an empty store yields a single result with empty_res set. For each result of a finish the list
// heads are compared one per cycle through the single read port of the value memory, then the
// last comparison settles, the winner's link is read and its list head advanced, and the result
// is offered until it is accepted. No input is taken until the final result of a finish has been
// accepted. No clearing pass is needed after reset.
module k_way_list_merge_top #(
  parameter int LISTS = kwlm_pkg::LISTS_DEF,
  parameter int CAPACITY = kwlm_pkg::CAPACITY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic        [kwlm_pkg::LIST_W-1:0]   list_number_i,
  input  logic signed [kwlm_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [kwlm_pkg::VALUE_W-1:0]  value_res_o,
  output logic        [kwlm_pkg::LIST_W-1:0]   list_number_res_o,
  output logic                                 last_o,
  output logic                                 empty_res_o,
  output logic                                 dropped_o
);

  kwlm_pkg::cmd_t cmd;
  kwlm_pkg::sts_t sts;

  // Sequencing of load and merge steps.
  kwlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Element store, list heads and minimum search.
  kwlm_dp #(
    .LISTS    (LISTS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .list_number_i     (list_number_i),
    .value_i           (value_i),
    .value_res_o       (value_res_o),
    .list_number_res_o (list_number_res_o),
    .last_o            (last_o),
    .empty_res_o       (empty_res_o),
    .dropped_o         (dropped_o)
  );

endmodule
